[rtl/bdp_pkg.sv]
package bdp_pkg;

	// field and datapath widths
	localparam int DATA_W    = 61;
	localparam int WORD_W    = 64;
	localparam int HALF_W    = 32;
	localparam int ACC_W     = 128;
	localparam int CFG_IDX_W = 3;

	// register map: each modulus set takes three consecutive indexes
	localparam int NUM_MODULI_DEF = 2;
	localparam int REGS_PER_SET   = 3;
	localparam int MOD_OFS        = 0;
	localparam int RLO_OFS        = 1;
	localparam int RHI_OFS        = 2;
	localparam logic [DATA_W-1:0] MOD_RESET = DATA_W'(2);

	// microcode length and step counter width
	localparam int MC_LEN = 25;
	localparam int STEP_W = 5;

	// multiplier operand sources
	typedef enum logic [1:0] {
		X_A  = 2'd0,
		X_P0 = 2'd1,
		X_P1 = 2'd2,
		X_Q  = 2'd3
	} x_src_t;

	typedef enum logic [1:0] {
		Y_B  = 2'd0,
		Y_R0 = 2'd1,
		Y_R1 = 2'd2,
		Y_N  = 2'd3
	} y_src_t;

	// accumulator update: add, load, or drop the low word then add
	typedef enum logic [1:0] {
		ACC_ADD  = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_SHR  = 2'd2
	} acc_mode_t;

	// control handed to the multiply-accumulate unit
	typedef struct packed {
		logic      en;
		logic [1:0] shift;   // partial product offset in 32-bit units
		acc_mode_t mode;
		logic      save_p;  // capture the 128-bit result as the product a*b
		logic      save_q;  // capture the low word as the quotient estimate
	} mac_ctl_t;

	// one microcode step
	typedef struct packed {
		x_src_t   xs;
		logic     xh;
		y_src_t   ys;
		logic     yh;
		mac_ctl_t ctl;
	} uop_t;

	function automatic uop_t mk(input x_src_t xs, input logic xh, input y_src_t ys,
			input logic yh, input logic [1:0] sh, input acc_mode_t mode,
			input logic sp, input logic sq);
		uop_t u;
		u.xs         = xs;
		u.xh         = xh;
		u.ys         = ys;
		u.yh         = yh;
		u.ctl.en     = 1'b1;
		u.ctl.shift  = sh;
		u.ctl.mode   = mode;
		u.ctl.save_p = sp;
		u.ctl.save_q = sq;
		return u;
	endfunction

	function automatic uop_t nop();
		uop_t u;
		u = '0;
		return u;
	endfunction

	// Barrett sequence as 32x32 partial products:
	//   a*b -> P; zz=P0*R0; mid = zz>>64 + P0*R1 + P1*R0;
	//   q = low(mid>>64 + P1*R1); then low(q*n)
	function automatic uop_t uop(input logic [STEP_W-1:0] idx);
		uop_t u;
		case (idx)
			STEP_W'(0):  u = mk(X_A,  1'b0, Y_B,  1'b0, 2'd0, ACC_LOAD, 1'b0, 1'b0);
			STEP_W'(1):  u = mk(X_A,  1'b0, Y_B,  1'b1, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(2):  u = mk(X_A,  1'b1, Y_B,  1'b0, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(3):  u = mk(X_A,  1'b1, Y_B,  1'b1, 2'd2, ACC_ADD,  1'b1, 1'b0);
			STEP_W'(5):  u = mk(X_P0, 1'b0, Y_R0, 1'b0, 2'd0, ACC_LOAD, 1'b0, 1'b0);
			STEP_W'(6):  u = mk(X_P0, 1'b0, Y_R0, 1'b1, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(7):  u = mk(X_P0, 1'b1, Y_R0, 1'b0, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(8):  u = mk(X_P0, 1'b1, Y_R0, 1'b1, 2'd2, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(9):  u = mk(X_P0, 1'b0, Y_R1, 1'b0, 2'd0, ACC_SHR,  1'b0, 1'b0);
			STEP_W'(10): u = mk(X_P0, 1'b0, Y_R1, 1'b1, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(11): u = mk(X_P0, 1'b1, Y_R1, 1'b0, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(12): u = mk(X_P0, 1'b1, Y_R1, 1'b1, 2'd2, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(13): u = mk(X_P1, 1'b0, Y_R0, 1'b0, 2'd0, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(14): u = mk(X_P1, 1'b0, Y_R0, 1'b1, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(15): u = mk(X_P1, 1'b1, Y_R0, 1'b0, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(16): u = mk(X_P1, 1'b1, Y_R0, 1'b1, 2'd2, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(17): u = mk(X_P1, 1'b0, Y_R1, 1'b0, 2'd0, ACC_SHR,  1'b0, 1'b0);
			STEP_W'(18): u = mk(X_P1, 1'b0, Y_R1, 1'b1, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(19): u = mk(X_P1, 1'b1, Y_R1, 1'b0, 2'd1, ACC_ADD,  1'b0, 1'b1);
			STEP_W'(21): u = mk(X_Q,  1'b0, Y_N,  1'b0, 2'd0, ACC_LOAD, 1'b0, 1'b0);
			STEP_W'(22): u = mk(X_Q,  1'b0, Y_N,  1'b1, 2'd1, ACC_ADD,  1'b0, 1'b0);
			STEP_W'(23): u = mk(X_Q,  1'b1, Y_N,  1'b0, 2'd1, ACC_ADD,  1'b0, 1'b0);
			default:     u = nop();
		endcase
		return u;
	endfunction

endpackage

[rtl/bdp_mac.sv]
// Shared 32x32 multiplier with a 128-bit accumulator behind it.
// Stage 1 registers the product, stage 2 adds it at its offset.
module bdp_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bdp_pkg::mac_ctl_t          ctl,
	input  logic [bdp_pkg::HALF_W-1:0] x_word,
	input  logic [bdp_pkg::HALF_W-1:0] y_word,
	output logic [bdp_pkg::ACC_W-1:0]  acc,
	output logic [bdp_pkg::ACC_W-1:0]  p,
	output logic [bdp_pkg::WORD_W-1:0] q
);

	bdp_pkg::mac_ctl_t                ctl_s1;
	logic [bdp_pkg::WORD_W-1:0]       prod_s1;
	logic [bdp_pkg::ACC_W-1:0]        acc_q;
	logic [bdp_pkg::ACC_W-1:0]        p_q;
	logic [bdp_pkg::WORD_W-1:0]       q_q;
	logic [bdp_pkg::ACC_W-1:0]        pp_shift;
	logic [bdp_pkg::ACC_W-1:0]        acc_base;
	logic [bdp_pkg::ACC_W-1:0]        acc_d;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_s1 <= bdp_pkg::WORD_W'(x_word) * bdp_pkg::WORD_W'(y_word);
		end
	end

	// place the partial product and pick the base
	always_comb begin
		pp_shift = bdp_pkg::ACC_W'(prod_s1) << (ctl_s1.shift * bdp_pkg::HALF_W);
		unique case (ctl_s1.mode)
			bdp_pkg::ACC_LOAD: acc_base = '0;
			bdp_pkg::ACC_SHR:  acc_base = acc_q >> bdp_pkg::WORD_W;
			default:           acc_base = acc_q;
		endcase
		acc_d = acc_base + pp_shift;
	end

	// accumulate stage, with captures of P and q
	always_ff @(posedge clk) begin
		if (ctl_s1.en) begin
			acc_q <= acc_d;
			if (ctl_s1.save_p) begin
				p_q <= acc_d;
			end
			if (ctl_s1.save_q) begin
				q_q <= acc_d[bdp_pkg::WORD_W-1:0];
			end
		end
	end

	assign acc = acc_q;
	assign p   = p_q;
	assign q   = q_q;

endmodule

[rtl/barrett_modular_dot_product.sv]
// Channel  Handshake             Payload
// term     term_valid/term_stall a_value, b_value, modulus_select, last_term
// sum      sum_valid/sum_stall   dot_sum
// cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One term runs 25 microcode steps through the single shared 32x32
// multiplier (22 partial products plus three drain steps), then four
// reduction and add steps, and the idle state in which the next term is taken.
// The result word sits in an output register; a stalled result holds the
// block at the final step only when a new result is ready behind it.
// Reset: running sum 0, moduli 2, ratios 0, no result pending.
module barrett_modular_dot_product #(
	parameter int NUM_MODULI = bdp_pkg::NUM_MODULI_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          term_valid,
	output logic                          term_stall,
	input  logic [bdp_pkg::DATA_W-1:0]    a_value,
	input  logic [bdp_pkg::DATA_W-1:0]    b_value,
	input  logic                          modulus_select,
	input  logic                          last_term,
	output logic                          sum_valid,
	input  logic                          sum_stall,
	output logic [bdp_pkg::DATA_W-1:0]    dot_sum,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdp_pkg::WORD_W-1:0]    cfg_data
);

	localparam int SEL_W = (NUM_MODULI > 1) ? $clog2(NUM_MODULI) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_RED  = 6'b000100,
		S_CORR = 6'b001000,
		S_ADD  = 6'b010000,
		S_FOLD = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [bdp_pkg::STEP_W-1:0]      step_q;
	logic [bdp_pkg::DATA_W-1:0]      mod_q [NUM_MODULI];
	logic [bdp_pkg::WORD_W-1:0]      rlo_q [NUM_MODULI];
	logic [bdp_pkg::WORD_W-1:0]      rhi_q [NUM_MODULI];
	logic [bdp_pkg::DATA_W-1:0]      a_q;
	logic [bdp_pkg::DATA_W-1:0]      b_q;
	logic [SEL_W-1:0]                sel_q;
	logic                            last_q;
	logic [bdp_pkg::DATA_W-1:0]      sum_q;
	logic [bdp_pkg::WORD_W-1:0]      r_q;
	logic [bdp_pkg::WORD_W:0]        s_q;
	logic                            out_valid_q;
	logic [bdp_pkg::DATA_W-1:0]      out_q;

	bdp_pkg::uop_t                   uop_cur;
	bdp_pkg::mac_ctl_t               mac_ctl;
	logic [bdp_pkg::WORD_W-1:0]      x_full;
	logic [bdp_pkg::WORD_W-1:0]      y_full;
	logic [bdp_pkg::HALF_W-1:0]      x_word;
	logic [bdp_pkg::HALF_W-1:0]      y_word;
	logic [bdp_pkg::ACC_W-1:0]       acc;
	logic [bdp_pkg::ACC_W-1:0]       p;
	logic [bdp_pkg::WORD_W-1:0]      q;
	logic [bdp_pkg::WORD_W-1:0]      n_word;
	logic [bdp_pkg::WORD_W-1:0]      fold_lo;
	logic [bdp_pkg::DATA_W-1:0]      fold_sum;
	logic                            term_acc;
	logic                            out_free;

	assign term_stall = (state_q != S_IDLE);
	assign term_acc   = term_valid && !term_stall;
	assign cfg_ready  = 1'b1;
	assign sum_valid  = out_valid_q;
	assign dot_sum    = out_q;
	assign out_free   = !out_valid_q || !sum_stall;
	assign n_word     = bdp_pkg::WORD_W'(mod_q[sel_q]);

	// configuration registers, three per modulus set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_MODULI; k++) begin
				mod_q[k] <= bdp_pkg::MOD_RESET;
				rlo_q[k] <= '0;
				rhi_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			for (int k = 0; k < NUM_MODULI; k++) begin
				if (cfg_index == bdp_pkg::CFG_IDX_W'(k * bdp_pkg::REGS_PER_SET
						+ bdp_pkg::MOD_OFS)) begin
					mod_q[k] <= cfg_data[bdp_pkg::DATA_W-1:0];
				end
				if (cfg_index == bdp_pkg::CFG_IDX_W'(k * bdp_pkg::REGS_PER_SET
						+ bdp_pkg::RLO_OFS)) begin
					rlo_q[k] <= cfg_data;
				end
				if (cfg_index == bdp_pkg::CFG_IDX_W'(k * bdp_pkg::REGS_PER_SET
						+ bdp_pkg::RHI_OFS)) begin
					rhi_q[k] <= cfg_data;
				end
			end
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		uop_cur = bdp_pkg::uop(step_q);
		unique case (uop_cur.xs)
			bdp_pkg::X_A:  x_full = bdp_pkg::WORD_W'(a_q);
			bdp_pkg::X_P0: x_full = p[bdp_pkg::WORD_W-1:0];
			bdp_pkg::X_P1: x_full = p[bdp_pkg::ACC_W-1:bdp_pkg::WORD_W];
			default:       x_full = q;
		endcase
		unique case (uop_cur.ys)
			bdp_pkg::Y_B:  y_full = bdp_pkg::WORD_W'(b_q);
			bdp_pkg::Y_R0: y_full = rlo_q[sel_q];
			bdp_pkg::Y_R1: y_full = rhi_q[sel_q];
			default:       y_full = n_word;
		endcase
		x_word = uop_cur.xh ? x_full[bdp_pkg::WORD_W-1:bdp_pkg::HALF_W]
				: x_full[bdp_pkg::HALF_W-1:0];
		y_word = uop_cur.yh ? y_full[bdp_pkg::WORD_W-1:bdp_pkg::HALF_W]
				: y_full[bdp_pkg::HALF_W-1:0];
		mac_ctl    = uop_cur.ctl;
		mac_ctl.en = uop_cur.ctl.en && (state_q == S_MUL);
	end

	bdp_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x_word (x_word),
		.y_word (y_word),
		.acc    (acc),
		.p      (p),
		.q      (q)
	);

	// final modular add fold
	always_comb begin
		fold_lo = s_q[bdp_pkg::WORD_W-1:0];
		if (s_q[bdp_pkg::WORD_W] || fold_lo >= n_word) begin
			fold_lo = fold_lo - n_word;
		end
		fold_sum = fold_lo[bdp_pkg::DATA_W-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load on an emitted sum, free once taken
			if (state_q == S_FOLD && last_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !sum_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (term_acc) begin
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (step_q == bdp_pkg::STEP_W'(bdp_pkg::MC_LEN - 1)) begin
						state_q <= S_RED;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_RED:  state_q <= S_CORR;
				S_CORR: state_q <= S_ADD;
				S_ADD:  state_q <= S_FOLD;
				S_FOLD: begin
					if (!last_q) begin
						sum_q   <= fold_sum;
						state_q <= S_IDLE;
					end else if (out_free) begin
						sum_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// term capture and reduction datapath
	always_ff @(posedge clk) begin
		if (term_acc) begin
			a_q    <= a_value;
			b_q    <= b_value;
			sel_q  <= (NUM_MODULI > 1) ? SEL_W'(modulus_select) : '0;
			last_q <= last_term;
		end
		if (state_q == S_RED) begin
			r_q <= p[bdp_pkg::WORD_W-1:0] - acc[bdp_pkg::WORD_W-1:0];
		end
		if (state_q == S_CORR && r_q >= n_word) begin
			r_q <= r_q - n_word;
		end
		if (state_q == S_ADD) begin
			s_q <= (bdp_pkg::WORD_W + 1)'(sum_q) + (bdp_pkg::WORD_W + 1)'(r_q);
		end
		if (state_q == S_FOLD && last_q && out_free) begin
			out_q <= fold_sum;
		end
	end

	// a new result only comes out of the fold step
	a_rise_from_fold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FOLD))
		else $error("result raised outside fold step");

	// an emitted sum leaves the running sum cleared
	a_clear_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (sum_q == '0))
		else $error("running sum not cleared on emit");

	// an accepted term starts the microcode at its first step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		term_acc |=> (state_q == S_MUL && step_q == '0))
		else $error("term did not start the multiply sequence");

	// step counter never runs past the microcode
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (step_q <= bdp_pkg::STEP_W'(bdp_pkg::MC_LEN - 1)))
		else $error("microcode step out of range");

	// a pending result is not overwritten while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sum_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result lost");

endmodule

[bench/barrett_modular_dot_product_test.sv]
`timescale 1ns / 100ps

module barrett_modular_dot_product_test;

	localparam int DATA_W        = bdp_pkg::DATA_W;
	localparam int WORD_W        = bdp_pkg::WORD_W;
	localparam int ACC_W         = bdp_pkg::ACC_W;
	localparam int CFG_IDX_W     = bdp_pkg::CFG_IDX_W;
	localparam int REGS_PER_SET  = bdp_pkg::REGS_PER_SET;
	localparam int MOD_OFS       = bdp_pkg::MOD_OFS;
	localparam int RLO_OFS       = bdp_pkg::RLO_OFS;
	localparam int RHI_OFS       = bdp_pkg::RHI_OFS;

	localparam int NUM_SETS      = bdp_pkg::NUM_MODULI_DEF;
	localparam int SUM_W         = WORD_W + 1;
	localparam int RAT_W         = ACC_W + 1;
	localparam int SETTLE_CYCLES = 80;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 500;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = CFG_IDX_W'(7);
	localparam logic [DATA_W-1:0]    MOD_MAX      = '1;
	localparam logic [DATA_W-1:0]    COEF_MAX     = MOD_MAX - DATA_W'(1);

	typedef struct {
		logic [DATA_W-1:0] modulus;
		logic [WORD_W-1:0] ratio_lo;
		logic [WORD_W-1:0] ratio_hi;
	} mod_set_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 term_valid;
	logic                 term_stall;
	logic [DATA_W-1:0]    a_value;
	logic [DATA_W-1:0]    b_value;
	logic                 modulus_select;
	logic                 last_term;
	logic                 sum_valid;
	logic                 sum_stall;
	logic [DATA_W-1:0]    dot_sum;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	// shadow of the block's registers and accumulator
	mod_set_t          mod_sets[NUM_SETS];
	logic [DATA_W-1:0] running_total;
	logic [DATA_W-1:0] expected_sums[$];

	int err_count;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_hold_cycles;

	barrett_modular_dot_product DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.term_valid     (term_valid),
		.term_stall     (term_stall),
		.a_value        (a_value),
		.b_value        (b_value),
		.modulus_select (modulus_select),
		.last_term      (last_term),
		.sum_valid      (sum_valid),
		.sum_stall      (sum_stall),
		.dot_sum        (dot_sum),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Barrett product: high part of P*R as quotient, then one correction
	function automatic logic [WORD_W-1:0] barrett_product(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input mod_set_t s);
		logic [ACC_W-1:0]  prod, zz, zo, oz, oo, mid;
		logic [WORD_W-1:0] p0, p1, n, q, r;
		n    = WORD_W'(s.modulus);
		prod = ACC_W'(a) * ACC_W'(b);
		p0   = prod[WORD_W-1:0];
		p1   = prod[ACC_W-1:WORD_W];
		zz   = ACC_W'(p0) * ACC_W'(s.ratio_lo);
		zo   = ACC_W'(p0) * ACC_W'(s.ratio_hi);
		oz   = ACC_W'(p1) * ACC_W'(s.ratio_lo);
		oo   = ACC_W'(p1) * ACC_W'(s.ratio_hi);
		mid  = (zz >> WORD_W) + zo + oz;
		q    = mid[ACC_W-1:WORD_W] + oo[WORD_W-1:0];
		r    = p0 - q * n;
		if (r >= n) begin
			r = r - n;
		end
		return r;
	endfunction

	// modular add with the carry kept in a 65-bit sum
	function automatic logic [DATA_W-1:0] mod_accumulate(input logic [DATA_W-1:0] acc,
			input logic [WORD_W-1:0] t, input logic [DATA_W-1:0] n);
		logic [SUM_W-1:0] s;
		s = SUM_W'(acc) + SUM_W'(t);
		if (s >= SUM_W'(n)) begin
			s = s - SUM_W'(n);
		end
		return s[DATA_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] barrett_ratio(input logic [DATA_W-1:0] n);
		logic [RAT_W-1:0] num;
		num        = '0;
		num[ACC_W] = 1'b1;
		return ACC_W'(num / RAT_W'(n));
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [DATA_W-1:0] rand_modulus();
		int                w;
		logic [WORD_W-1:0] v;
		w    = $urandom_range(DATA_W, 2);
		v    = rand_word() & ((WORD_W'(1) << w) - WORD_W'(1));
		v[w-1] = 1'b1;
		if (v < WORD_W'(2)) begin
			v = WORD_W'(2);
		end
		return v[DATA_W-1:0];
	endfunction

	// coefficient below n, or any field value but all ones when noisy or n is zero
	function automatic logic [DATA_W-1:0] rand_coef(input logic [DATA_W-1:0] n, input bit noisy);
		logic [DATA_W-1:0] v;
		int                pick;
		pick = $urandom_range(99);
		if (noisy || n == '0) begin
			v = DATA_W'(rand_word());
			if (v == MOD_MAX) begin
				v = COEF_MAX;
			end
		end else if (pick < 4) begin
			v = n - DATA_W'(1);
		end else if (pick < 7) begin
			v = '0;
		end else begin
			v = DATA_W'(rand_word() % WORD_W'(n));
		end
		return v;
	endfunction

	// fold one accepted word into the shadow accumulator
	task automatic absorb_term(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input logic sel, input logic last);
		int                k;
		logic [WORD_W-1:0] prod;
		k = int'(sel);
		if (k >= NUM_SETS) begin
			k = 0;
		end
		prod          = barrett_product(a, b, mod_sets[k]);
		running_total = mod_accumulate(running_total, prod, mod_sets[k].modulus);
		if (last) begin
			expected_sums.push_back(running_total);
			running_total = '0;
		end
	endtask

	// offer one word on the term channel, with random gaps ahead of it
	task automatic send_term(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input logic sel, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			term_valid = 1'b0;
			@(negedge clk);
		end
		term_valid     = 1'b1;
		a_value        = a;
		b_value        = b;
		modulus_select = sel;
		last_term      = last;
		do @(posedge clk); while (term_stall);
		absorb_term(a, b, sel, last);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		int k;
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		if (int'(idx) < NUM_SETS * REGS_PER_SET) begin
			k = int'(idx) / REGS_PER_SET;
			case (int'(idx) % REGS_PER_SET)
				MOD_OFS: mod_sets[k].modulus  = data[DATA_W-1:0];
				RLO_OFS: mod_sets[k].ratio_lo = data;
				RHI_OFS: mod_sets[k].ratio_hi = data;
				default: ;
			endcase
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_set(input int k, input logic [WORD_W-1:0] n, input logic [ACC_W-1:0] ratio);
		cfg_write(CFG_IDX_W'(k * REGS_PER_SET + MOD_OFS), n);
		cfg_write(CFG_IDX_W'(k * REGS_PER_SET + RLO_OFS), ratio[WORD_W-1:0]);
		cfg_write(CFG_IDX_W'(k * REGS_PER_SET + RHI_OFS), ratio[ACC_W-1:WORD_W]);
	endtask

	task automatic load_matched_set(input int k);
		logic [DATA_W-1:0] n;
		n = rand_modulus();
		load_set(k, WORD_W'(n), barrett_ratio(n));
	endtask

	// let every sum come back and any trailing term finish before a write
	task automatic wait_idle();
		@(negedge clk);
		term_valid = 1'b0;
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic send_dot(input logic sel, input int len, input int noisy_pct);
		int   k;
		logic s;
		for (k = 0; k < len; k++) begin
			// rare selector flip inside one dot product
			s = ($urandom_range(99) < 3) ? ~sel : sel;
			send_term(rand_coef(mod_sets[int'(s)].modulus, $urandom_range(99) < noisy_pct),
				rand_coef(mod_sets[int'(s)].modulus, $urandom_range(99) < noisy_pct),
				s, k == len - 1);
		end
	endtask

	// reset values: moduli 2, zero ratios
	task automatic test_reset_values();
		send_term('0, '0, 1'b0, 1'b1);
		send_term(COEF_MAX, COEF_MAX, 1'b1, 1'b0);
		send_term(COEF_MAX, DATA_W'(3), 1'b1, 1'b1);
	endtask

	// largest and smallest moduli with matched ratios, coefficient extremes
	task automatic test_extremes();
		wait_idle();
		load_set(0, WORD_W'(MOD_MAX), barrett_ratio(MOD_MAX));
		load_set(1, WORD_W'(2), barrett_ratio(DATA_W'(2)));
		send_term(MOD_MAX - DATA_W'(1), MOD_MAX - DATA_W'(1), 1'b0, 1'b0);
		send_term(MOD_MAX - DATA_W'(1), MOD_MAX - DATA_W'(1), 1'b0, 1'b0);
		send_term('0, MOD_MAX - DATA_W'(1), 1'b0, 1'b1);
		send_term(DATA_W'(1), DATA_W'(1), 1'b1, 1'b0);
		send_term(DATA_W'(1), '0, 1'b1, 1'b1);
		send_term(COEF_MAX, COEF_MAX, 1'b1, 1'b1);
	endtask

	// degenerate moduli, masked upper data bits, writes to unused indexes
	task automatic test_special_cases();
		logic [DATA_W-1:0] n;
		wait_idle();
		load_set(0, '0, {rand_word(), rand_word()});
		load_set(1, WORD_W'(1), '1);
		send_term(rand_coef('0, 1'b1), rand_coef('0, 1'b1), 1'b0, 1'b1);
		send_term(rand_coef('0, 1'b1), rand_coef('0, 1'b1), 1'b1, 1'b0);
		send_term(rand_coef('0, 1'b1), rand_coef('0, 1'b1), 1'b1, 1'b1);
		wait_idle();
		n = rand_modulus();
		load_set(0, {3'b111, n}, barrett_ratio(n));
		cfg_write(IDX_SPARE_LO, rand_word());
		cfg_write(IDX_SPARE_HI, rand_word());
		send_term(n - DATA_W'(1), n - DATA_W'(1), 1'b0, 1'b0);
		send_term(rand_coef(n, 1'b0), rand_coef(n, 1'b0), 1'b0, 1'b1);
		send_term(rand_coef(DATA_W'(1), 1'b1), rand_coef(DATA_W'(1), 1'b1), 1'b1, 1'b1);
	endtask

	// well-formed dot products over fresh moduli; last phase uses stray ratios
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int   ph;
		int   sent;
		int   len;
		int   noisy_pct;
		logic sel;
		for (ph = 0; ph < 4; ph++) begin
			wait_idle();
			set_idling(send_pct, recv_pct);
			if (ph == 3) begin
				load_set(0, WORD_W'(rand_modulus()), {rand_word(), rand_word()});
				load_set(1, WORD_W'(rand_modulus()), {rand_word(), rand_word()});
				noisy_pct = 40;
			end else begin
				load_matched_set(0);
				load_matched_set(1);
				noisy_pct = 8;
			end
			sent = 0;
			while (sent < 125) begin
				len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(20, 7);
				sel = 1'($urandom_range(1));
				send_dot(sel, len, noisy_pct);
				sent += len;
			end
		end
	endtask

	// receiver holds off while single-term sums pile up behind it
	task automatic test_output_backpressure();
		int k;
		wait_idle();
		set_idling(0, 0);
		load_matched_set(0);
		load_matched_set(1);
		stall_hold_cycles = HOLD_CYCLES;
		for (k = 0; k < 12; k++) begin
			send_dot(1'($urandom_range(1)), 1, 0);
		end
		send_dot(1'b0, 5, 0);
	endtask

	// sum channel stall: long hold when asked, otherwise random
	always @(negedge clk) begin
		if (stall_hold_cycles > 0) begin
			sum_stall = 1'b1;
			stall_hold_cycles--;
		end else begin
			sum_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	// compare each accepted sum word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && sum_valid && !sum_stall) begin
			if (expected_sums.size() == 0) begin
				$display("%0t: dot_sum mismatch expected none actual %h", $time, dot_sum);
				err_count++;
			end else begin
				if (dot_sum !== expected_sums[0]) begin
					$display("%0t: dot_sum mismatch expected %h actual %h", $time,
						expected_sums[0], dot_sum);
					err_count++;
				end
				void'(expected_sums.pop_front());
			end
		end
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int waited;
		arst_n            = 1'b0;
		term_valid        = 1'b0;
		a_value           = '0;
		b_value           = '0;
		modulus_select    = 1'b0;
		last_term         = 1'b0;
		sum_stall         = 1'b0;
		cfg_valid         = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		err_count         = 0;
		stall_hold_cycles = 0;
		running_total     = '0;
		set_idling(0, 0);
		for (int k = 0; k < NUM_SETS; k++) begin
			mod_sets[k].modulus  = bdp_pkg::MOD_RESET;
			mod_sets[k].ratio_lo = '0;
			mod_sets[k].ratio_hi = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_extremes();
		test_special_cases();
		test_random_traffic(12, 51);
		test_random_traffic(51, 12);
		test_random_traffic(0, 0);
		test_output_backpressure();

		// drain outstanding sums, bounded
		@(negedge clk);
		term_valid = 1'b0;
		waited = 0;
		while (expected_sums.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_sums.size() != 0) begin
			$display("%0t: %0d dot_sum words never arrived, next expected %h", $time,
				expected_sums.size(), expected_sums[0]);
			err_count++;
		end
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
